>>> hdl/h264fua_pkg.sv
package h264fua_pkg;

    // Queue between the classifier and the beat sequencer
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // FU-A constants
    localparam logic [7:0] NAL_TYPE_BITS = 8'h1F;
    localparam logic [7:0] S_BIT         = 8'h80;
    localparam logic [7:0] E_BIT         = 8'h40;
    localparam logic [7:0] FU_A_TYPE     = 8'h1C;

    localparam logic [15:0] MTU_RESET = 16'd1500;
    localparam logic [15:0] MTU_MIN   = 16'd3;

    // One accepted byte's work: an optional indicator/FU header pair, then one data beat
    typedef struct packed {
        logic        hdr_en;
        logic [7:0]  ind;
        logic [7:0]  hdr;
        logic [7:0]  data;
        logic        pf;
        logic        pl;
        logic        fs;
        logic        fe;
        logic [15:0] pn;
    } fua_entry_t;

endpackage

>>> hdl/h264fua_front.sv
module h264fua_front
    import h264fua_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        mtu_wr_en,
    input  logic [15:0] mtu_wr_data,
    input  logic        in_fire,
    input  logic [7:0]  nal_byte,
    input  logic        is_first,
    input  logic [15:0] nal_length,
    input  logic        frame_start_in,
    input  logic        frame_end_in,
    output logic        push,
    output fua_entry_t  entry
);

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_SINGLE = 2'd1;
    localparam logic [1:0] MODE_FRAG   = 2'd2;

    logic [15:0] mtu_reg;
    logic [1:0]  mode_reg, mode_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [15:0] fill_reg, fill_next;
    logic [7:0]  ind_reg, ind_next;
    logic [4:0]  utype_reg, utype_next;
    logic        first_frag_reg, first_frag_next;
    logic [1:0]  flags_reg, flags_next;
    logic [15:0] counter_reg, counter_next;

    logic [15:0] eff_mtu;
    logic [15:0] pay;
    logic        bump;
    logic [15:0] cnt1;
    logic [15:0] len1;
    logic [16:0] end_sum;
    logic        is_end;
    logic        is_start;
    logic [15:0] bl_dec;
    logic [16:0] fill_inc;
    logic        done;
    logic        frag_fs;
    logic        frag_fe;

    // Effective mtu and payload size
    assign eff_mtu = (mtu_reg < MTU_MIN) ? MTU_MIN : mtu_reg;
    assign pay     = eff_mtu - 16'd2;

    // Unit start terms
    assign bump = (mode_reg == MODE_SINGLE) || ((mode_reg == MODE_FRAG) && (fill_reg != 16'd0));
    assign cnt1 = counter_reg + {15'd0, bump};
    assign len1 = (nal_length == 16'd0) ? 16'd1 : nal_length;

    // Fragment terms
    assign end_sum  = {1'b0, bytes_left_reg} + {1'b0, fill_reg};
    assign is_end   = end_sum <= {1'b0, pay};
    assign is_start = first_frag_reg && !is_end;
    assign frag_fs  = is_start && flags_reg[0];
    assign frag_fe  = is_end && flags_reg[1];
    assign bl_dec   = bytes_left_reg - 16'd1;
    assign fill_inc = {1'b0, fill_reg} + 17'd1;
    assign done     = (bl_dec == 16'd0) || (fill_inc >= {1'b0, pay});

    // Classify one byte
    always_comb begin
        mode_next       = mode_reg;
        bytes_left_next = bytes_left_reg;
        fill_next       = fill_reg;
        ind_next        = ind_reg;
        utype_next      = utype_reg;
        first_frag_next = first_frag_reg;
        flags_next      = flags_reg;
        counter_next    = counter_reg;
        push            = 1'b0;
        entry           = '0;
        entry.data      = nal_byte;
        entry.ind       = ind_reg;
        entry.hdr       = (is_start ? S_BIT : 8'h00) | (is_end ? E_BIT : 8'h00)
                        | {3'b000, utype_reg};
        if (in_fire) begin
            if (is_first) begin
                flags_next = {frame_end_in, frame_start_in};
                fill_next  = 16'd0;
                counter_next = cnt1;
                if (len1 <= eff_mtu) begin
                    push     = 1'b1;
                    entry.pf = 1'b1;
                    entry.pl = (len1 == 16'd1);
                    entry.fs = frame_start_in;
                    entry.fe = frame_end_in;
                    entry.pn = cnt1;
                    if (len1 == 16'd1) begin
                        counter_next    = cnt1 + 16'd1;
                        mode_next       = MODE_IDLE;
                        bytes_left_next = 16'd0;
                    end else begin
                        mode_next       = MODE_SINGLE;
                        bytes_left_next = len1 - 16'd1;
                    end
                end else begin
                    mode_next       = MODE_FRAG;
                    bytes_left_next = len1 - 16'd1;
                    ind_next        = (nal_byte & ~NAL_TYPE_BITS) | FU_A_TYPE;
                    utype_next      = nal_byte[4:0];
                    first_frag_next = 1'b1;
                end
            end else begin
                unique case (mode_reg)
                    MODE_SINGLE: begin
                        push            = 1'b1;
                        bytes_left_next = bl_dec;
                        entry.pl        = (bl_dec == 16'd0);
                        entry.fs        = flags_reg[0];
                        entry.fe        = flags_reg[1];
                        entry.pn        = counter_reg;
                        if (bl_dec == 16'd0) begin
                            counter_next = counter_reg + 16'd1;
                            mode_next    = MODE_IDLE;
                        end
                    end
                    MODE_FRAG: begin
                        push            = 1'b1;
                        entry.hdr_en    = (fill_reg == 16'd0);
                        entry.pl        = done;
                        entry.fs        = frag_fs;
                        entry.fe        = frag_fe;
                        entry.pn        = counter_reg;
                        bytes_left_next = bl_dec;
                        fill_next       = fill_inc[15:0];
                        if (done) begin
                            counter_next    = counter_reg + 16'd1;
                            fill_next       = 16'd0;
                            first_frag_next = 1'b0;
                            if (bl_dec == 16'd0) begin
                                mode_next = MODE_IDLE;
                            end
                        end
                    end
                    default: begin
                        // drop stray bytes outside a unit
                    end
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mtu_reg        <= MTU_RESET;
            mode_reg       <= MODE_IDLE;
            bytes_left_reg <= 16'd0;
            fill_reg       <= 16'd0;
            ind_reg        <= 8'd0;
            utype_reg      <= 5'd0;
            first_frag_reg <= 1'b0;
            flags_reg      <= 2'd0;
            counter_reg    <= 16'd0;
        end else begin
            if (mtu_wr_en) begin
                mtu_reg <= mtu_wr_data;
            end
            mode_reg       <= mode_next;
            bytes_left_reg <= bytes_left_next;
            fill_reg       <= fill_next;
            ind_reg        <= ind_next;
            utype_reg      <= utype_next;
            first_frag_reg <= first_frag_next;
            flags_reg      <= flags_next;
            counter_reg    <= counter_next;
        end
    end

endmodule

>>> hdl/h264fua_queue.sv
module h264fua_queue
    import h264fua_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  fua_entry_t wr_entry,
    input  logic       pop,
    output fua_entry_t rd_entry,
    output logic       full,
    output logic       empty
);

    fua_entry_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign rd_entry = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    // Hold pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hdl/h264fua_back.sv
module h264fua_back
    import h264fua_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  fua_entry_t  head,
    input  logic        empty,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic        m_tuser,
    output logic        m_tlast
);

    localparam logic [1:0] BEAT_IND  = 2'd0;
    localparam logic [1:0] BEAT_HDR  = 2'd1;
    localparam logic [1:0] BEAT_DATA = 2'd2;

    logic [1:0]  beat_reg, beat_next;
    logic        valid_reg, valid_next;
    logic [31:0] data_reg, data_next;
    logic        user_reg, user_next;
    logic        last_reg, last_next;
    logic        load;
    logic [7:0]  beat_byte;
    logic [1:0]  beat_sel;

    assign load     = !valid_reg || m_tready;
    assign beat_sel = head.hdr_en ? beat_reg : BEAT_DATA;

    // Pick the next beat of the head entry
    always_comb begin
        beat_next  = beat_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        beat_byte  = head.data;
        if (load) begin
            valid_next = !empty;
            if (!empty) begin
                unique case (beat_sel)
                    BEAT_IND: begin
                        beat_byte = head.ind;
                        user_next = 1'b1;
                        last_next = 1'b0;
                        beat_next = BEAT_HDR;
                    end
                    BEAT_HDR: begin
                        beat_byte = head.hdr;
                        user_next = 1'b0;
                        last_next = 1'b0;
                        beat_next = BEAT_DATA;
                    end
                    default: begin
                        beat_byte = head.data;
                        user_next = head.pf;
                        last_next = head.pl;
                        beat_next = BEAT_IND;
                        pop       = 1'b1;
                    end
                endcase
                data_next = {6'd0, head.pn, head.fe, head.fs, beat_byte};
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg  <= BEAT_IND;
            valid_reg <= 1'b0;
        end else begin
            beat_reg  <= beat_next;
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

>>> hdl/h264_rtp_fu_a_packetizer.sv
// A byte's beats pass through its queue entry and then the output register.
// Throughput: one input byte per cycle while the queue has room; output runs at one beat
// per cycle while m_tready is high, so a fragment opening (indicator, FU header, payload
// byte) takes three output beats and the four-entry queue between classifier and sequencer
// soaks up the extra beats, holding off input only once it fills.
// Reset: aresetn is synchronous, active low; mtu returns to 1500, sequence number to zero.
module h264_rtp_fu_a_packetizer
    import h264fua_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        mtu_wr_en,
    input  logic [15:0] mtu_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // nal_byte[7:0], nal_length[23:8], frame_start_in[24],
                                   // frame_end_in[25], zero[31:26]
    input  logic        s_tuser,   // is_first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_byte[7:0], frame_start_out[8], frame_end_out[9],
                                   // packet_number[25:10], zero[31:26]
    output logic        m_tuser,   // packet_first
    output logic        m_tlast    // packet_last
);

    logic       in_fire;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;
    fua_entry_t wr_entry;
    fua_entry_t head;

    assign s_tready = !full;
    assign in_fire  = s_tvalid && s_tready;

    // Classify bytes and keep unit state
    h264fua_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .mtu_wr_en      (mtu_wr_en),
        .mtu_wr_data    (mtu_wr_data),
        .in_fire        (in_fire),
        .nal_byte       (s_tdata[7:0]),
        .is_first       (s_tuser),
        .nal_length     (s_tdata[23:8]),
        .frame_start_in (s_tdata[24]),
        .frame_end_in   (s_tdata[25]),
        .push           (push),
        .entry          (wr_entry)
    );

    // Decouple classifier from beat output
    h264fua_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .rd_entry (head),
        .full     (full),
        .empty    (empty)
    );

    // Sequence header and payload beats
    h264fua_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("queue read while empty");

    a_full_from_push: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(full) |-> $past(push))
        else $error("queue filled without a write");

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench
    import h264fua_pkg::*;
();

    localparam int STALL_CYCLES  = 100;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 50;

    typedef enum logic [1:0] {
        UNIT_IDLE,
        UNIT_SINGLE,
        UNIT_FRAG
    } unit_mode_e;

    // One output beat as the packetizer should produce it
    typedef struct packed {
        logic [7:0]  data;
        logic        pkt_first;
        logic        pkt_last;
        logic        frame_start;
        logic        frame_end;
        logic [15:0] seq;
    } pkt_beat_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        mtu_wr_en   = 1'b0;
    logic [15:0] mtu_wr_data = 16'd0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata     = 32'd0;  // nal_byte[7:0], nal_length[23:8], frame_start_in[24],
                                       // frame_end_in[25], zero[31:26]
    logic        s_tuser     = 1'b0;   // is_first
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;              // out_byte[7:0], frame_start_out[8], frame_end_out[9],
                                       // packet_number[25:10], zero[31:26]
    logic        m_tuser;              // packet_first
    logic        m_tlast;              // packet_last

    // Shared test controls
    logic        gaps_on        = 1'b1;
    int          stall_requests = 0;
    int          mismatch_count = 0;

    pkt_beat_t   expected_beats[$];

    // Shadow of the packetizer state
    logic [15:0] mtu_shadow       = MTU_RESET;
    unit_mode_e  unit_mode        = UNIT_IDLE;
    logic [15:0] remaining        = 16'd0;
    logic [15:0] fill             = 16'd0;
    logic [7:0]  fu_indicator     = 8'd0;
    logic [4:0]  orig_type        = 5'd0;
    logic        opening_fragment = 1'b0;
    logic        start_flag       = 1'b0;
    logic        end_flag         = 1'b0;
    logic [15:0] seq_num          = 16'd0;

    h264_rtp_fu_a_packetizer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .mtu_wr_en   (mtu_wr_en),
        .mtu_wr_data (mtu_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #4 aclk = ~aclk;

    function automatic void push_beat(input logic [7:0] data, input logic pf, input logic pl,
                                      input logic fs, input logic fe);
        pkt_beat_t beat;
        beat.data        = data;
        beat.pkt_first   = pf;
        beat.pkt_last    = pl;
        beat.frame_start = fs;
        beat.frame_end   = fe;
        beat.seq         = seq_num;
        expected_beats.insert(expected_beats.size(), beat);
    endfunction

    // Work out the beats caused by one accepted NAL byte and queue them
    task automatic packetize_byte(input logic [7:0] data, input logic unit_start,
                                  input logic [15:0] length, input logic fs_in,
                                  input logic fe_in);
        logic [15:0] eff;
        logic [15:0] pay;
        logic [15:0] len;
        logic        is_end;
        logic        is_start;
        logic        fs;
        logic        fe;
        logic        done;
        logic [7:0]  fu_header;
        eff = (mtu_shadow < MTU_MIN) ? MTU_MIN : mtu_shadow;
        pay = eff - 16'd2;
        if (unit_start) begin
            // a restart closes an open packet without a last beat, its number stays used
            if (unit_mode == UNIT_SINGLE || (unit_mode == UNIT_FRAG && fill != 16'd0))
                seq_num = seq_num + 16'd1;
            len = (length == 16'd0) ? 16'd1 : length;
            start_flag = fs_in;
            end_flag   = fe_in;
            fill       = 16'd0;
            if (len <= eff) begin
                push_beat(data, 1'b1, len == 16'd1, fs_in, fe_in);
                if (len == 16'd1) begin
                    seq_num   = seq_num + 16'd1;
                    unit_mode = UNIT_IDLE;
                    remaining = 16'd0;
                end else begin
                    unit_mode = UNIT_SINGLE;
                    remaining = len - 16'd1;
                end
            end else begin
                // fragmented unit: the NAL header byte only feeds the FU bytes
                unit_mode        = UNIT_FRAG;
                remaining        = len - 16'd1;
                fu_indicator     = (data & ~NAL_TYPE_BITS) | FU_A_TYPE;
                orig_type        = data[4:0];
                opening_fragment = 1'b1;
            end
        end else if (unit_mode == UNIT_SINGLE) begin
            remaining = remaining - 16'd1;
            done = (remaining == 16'd0);
            push_beat(data, 1'b0, done, start_flag, end_flag);
            if (done) begin
                seq_num   = seq_num + 16'd1;
                unit_mode = UNIT_IDLE;
            end
        end else if (unit_mode == UNIT_FRAG) begin
            is_end   = (int'(remaining) + int'(fill)) <= int'(pay);
            is_start = opening_fragment && !is_end;
            fs       = is_start ? start_flag : 1'b0;
            fe       = is_end ? end_flag : 1'b0;
            if (fill == 16'd0) begin
                fu_header = (is_start ? S_BIT : 8'h00) | (is_end ? E_BIT : 8'h00)
                          | {3'b000, orig_type};
                push_beat(fu_indicator, 1'b1, 1'b0, fs, fe);
                push_beat(fu_header, 1'b0, 1'b0, fs, fe);
            end
            remaining = remaining - 16'd1;
            fill      = fill + 16'd1;
            done      = (remaining == 16'd0) || (fill >= pay);
            push_beat(data, 1'b0, done, fs, fe);
            if (done) begin
                seq_num          = seq_num + 16'd1;
                fill             = 16'd0;
                opening_fragment = 1'b0;
                if (remaining == 16'd0)
                    unit_mode = UNIT_IDLE;
            end
        end
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got,
                     want);
        mismatch_count++;
    endtask

    // Offer one byte, hold it until taken, then predict its beats
    task automatic send_nal_byte(input logic [7:0] data, input logic unit_start,
                                 input logic [15:0] length, input logic fs, input logic fe);
        if (gaps_on) begin
            while ($urandom_range(99) < 24) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b000000, fe, fs, length, data};
        s_tuser  <= unit_start;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        packetize_byte(data, unit_start, length, fs, fe);
        @(negedge aclk);
    endtask

    // Continuation bytes carry junk in the fields that only a first byte uses
    task automatic send_body(input int count);
        for (int i = 0; i < count; i++)
            send_nal_byte(8'($urandom_range(255)), 1'b0, 16'($urandom_range(65535)),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    task automatic send_unit(input logic [7:0] head, input logic [15:0] length,
                             input logic fs, input logic fe, input int count);
        send_nal_byte(head, 1'b1, length, fs, fe);
        send_body(count - 1);
    endtask

    // Drop valid and wait until every predicted beat is out and the pipe is empty
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_mtu(input logic [15:0] value);
        mtu_wr_en   <= 1'b1;
        mtu_wr_data <= value;
        @(negedge aclk);
        mtu_wr_en   <= 1'b0;
        mtu_shadow  = value;
    endtask

    // Single-packet units at the reset mtu, including zero and one byte lengths
    task automatic test_single_units();
        send_unit(8'h00, 16'd1, 1'b1, 1'b1, 1);
        send_unit(8'hFF, 16'd0, 1'b0, 1'b0, 1);
        send_nal_byte(8'h65, 1'b1, 16'd3, 1'b1, 1'b0);
        send_nal_byte(8'hAA, 1'b0, 16'd0, 1'b0, 1'b0);
        send_nal_byte(8'h55, 1'b0, 16'hFFFF, 1'b1, 1'b1);
    endtask

    // Multi-fragment units, the smallest mtu clamped up to three
    task automatic test_fragmentation();
        settle_block();
        write_mtu(16'd5);
        send_unit(8'hFF, 16'd8, 1'b1, 1'b1, 8);
        settle_block();
        write_mtu(16'd0);
        send_unit(8'h41, 16'd4, 1'b1, 1'b0, 4);
    endtask

    task automatic test_corner_cases();
        settle_block();
        write_mtu(16'd4);
        // stray byte while idle
        send_nal_byte(8'h12, 1'b0, 16'd5, 1'b1, 1'b1);
        // restart inside a single packet, right after a header byte, inside a fragment
        send_unit(8'h21, 16'd3, 1'b1, 1'b1, 2);
        send_unit(8'h7C, 16'd6, 1'b0, 1'b1, 1);
        send_unit(8'hE5, 16'd9, 1'b1, 1'b1, 2);
        // grow mtu so the first fragment is also the last, then shrink it mid-fragment
        send_unit(8'h65, 16'd6, 1'b1, 1'b1, 1);
        settle_block();
        write_mtu(16'd20);
        send_body(2);
        settle_block();
        write_mtu(16'd3);
        send_body(3);
        // largest mtu and length, closed by a restart
        settle_block();
        write_mtu(16'hFFFF);
        send_unit(8'h80, 16'hFFFF, 1'b0, 1'b1, 2);
        send_unit(8'h09, 16'd1, 1'b1, 1'b1, 1);
    endtask

    // Stall the receiver long enough that the output queue fills and input stops
    task automatic test_backpressure();
        settle_block();
        gaps_on = 1'b0;
        write_mtu(16'd6);
        stall_requests <= stall_requests + 1;
        send_unit(8'h45, 16'd20, 1'b1, 1'b1, 20);
        settle_block();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        logic [15:0] mtu_plan [7];
        logic [15:0] eff;
        int          phase_bytes;
        int          phase_goal;
        int          pick;
        int          len;
        int          count;
        int          cap;
        mtu_plan = '{16'd3, 16'd0, 16'd5, 16'd9, 16'd2, 16'hFFFF, 16'd1500};
        mtu_plan[6] = 16'($urandom_range(3, 40));
        for (int p = 0; p < 7; p++) begin
            settle_block();
            write_mtu(mtu_plan[p]);
            // one long phase runs with no idling on either side
            gaps_on     = (p != 3);
            phase_goal  = (p == 3) ? 20 : 3;
            phase_bytes = 0;
            while (phase_bytes < phase_goal) begin
                pick = $urandom_range(99);
                eff  = (mtu_shadow < MTU_MIN) ? MTU_MIN : mtu_shadow;
                cap  = (eff > 16'd6) ? 20 : 3 * int'(eff);
                if (pick < 70) begin
                    len = $urandom_range(1, cap);
                    send_unit(8'($urandom_range(255)), 16'(len), 1'($urandom_range(1)),
                              1'($urandom_range(1)), len);
                    phase_bytes += len;
                end else if (pick < 80) begin
                    count = $urandom_range(1, 2);
                    send_body(count);
                    phase_bytes += count;
                end else if (pick < 92) begin
                    len   = $urandom_range(65535);
                    count = $urandom_range(1, 4);
                    send_unit(8'($urandom_range(255)), 16'(len), 1'($urandom_range(1)),
                              1'($urandom_range(1)), count);
                    phase_bytes += count;
                end else begin
                    send_unit(8'($urandom_range(255)), 16'd0, 1'($urandom_range(1)),
                              1'($urandom_range(1)), 1);
                    phase_bytes++;
                end
            end
        end
        settle_block();
        gaps_on = 1'b1;
    endtask

    // Receiver: random ready, with a long hold-off whenever one is requested
    initial begin : receiver
        int served = 0;
        forever begin
            @(negedge aclk);
            if (stall_requests != served) begin
                served++;
                repeat (STALL_CYCLES) begin
                    m_tready <= 1'b0;
                    @(negedge aclk);
                end
            end
            m_tready <= gaps_on ? ($urandom_range(99) >= 24) : 1'b1;
        end
    end

    // Compare each output beat with the oldest prediction
    always @(posedge aclk) begin : check_beats
        pkt_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_beats.size() == 0) begin
                report_mismatch("unexpected beat", m_tdata, 32'd0);
            end else begin
                want = expected_beats[0];
                expected_beats.delete(0);
                if (m_tdata[7:0] !== want.data)
                    report_mismatch("out_byte", 32'(m_tdata[7:0]), 32'(want.data));
                if (m_tuser !== want.pkt_first)
                    report_mismatch("packet_first", 32'(m_tuser), 32'(want.pkt_first));
                if (m_tlast !== want.pkt_last)
                    report_mismatch("packet_last", 32'(m_tlast), 32'(want.pkt_last));
                if (m_tdata[8] !== want.frame_start)
                    report_mismatch("frame_start_out", 32'(m_tdata[8]),
                                    32'(want.frame_start));
                if (m_tdata[9] !== want.frame_end)
                    report_mismatch("frame_end_out", 32'(m_tdata[9]), 32'(want.frame_end));
                if (m_tdata[25:10] !== want.seq)
                    report_mismatch("packet_number", 32'(m_tdata[25:10]), 32'(want.seq));
            end
        end
    end

    initial begin : watchdog
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin : run
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_single_units();
        test_fragmentation();
        test_corner_cases();
        test_backpressure();
        test_random_traffic();
        settle_block();
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
